// ===== sv/psc_pkg.sv =====
// psc_pkg: shared types and constants for the per-sender cooldown limiter
// used by psc_cell and per_sender_cooldown_limiter; no dependencies

package psc_pkg;

  // table size and derived widths
  localparam int unsigned SlotCount = 8;
  localparam int unsigned VictimW   = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  // field widths
  localparam int unsigned IdW   = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 32;

  // reset values of the cooldown registers
  localparam logic [CfgW-1:0] DirectCooldownRst  = CfgW'(15 * 1000);
  localparam logic [CfgW-1:0] ChannelCooldownRst = CfgW'(60 * 1000);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DIRECT_COOLDOWN  = 1'b0,
    CFG_CHANNEL_COOLDOWN = 1'b1
  } cfg_idx_e;

  // request token travelling down the row of cells
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             limited;
    logic [IdW-1:0]   sender;
    logic [TimeW-1:0] now;
    logic [CfgW-1:0]  cooldown;
  } token_t;

  // slot overwrite for the round-robin victim
  typedef struct packed {
    logic             en;
    logic [IdW-1:0]   sender;
    logic [TimeW-1:0] stamp;
  } slot_wr_t;

endpackage

// ===== sv/psc_cell.sv =====
// psc_cell: one table slot (sender id and last served time) with its matcher
// depends on psc_pkg for the token and slot write types

module psc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psc_pkg::token_t   tok_i,
  input  psc_pkg::slot_wr_t wr_i,
  output psc_pkg::token_t   tok_o
);

  logic [psc_pkg::IdW-1:0]   sender_q, sender_d;
  logic [psc_pkg::TimeW-1:0] stamp_q, stamp_d;
  psc_pkg::token_t           tok_q, tok_d;
  logic [psc_pkg::TimeW-1:0] elapsed;
  logic                      match;
  logic                      too_soon;

  // match only the first slot whose sender id equals the request's
  assign match    = tok_i.valid && !tok_i.hit && (sender_q == tok_i.sender);
  assign elapsed  = tok_i.now - stamp_q;
  assign too_soon = elapsed < tok_i.cooldown;

  // slot update and token hand-on
  always_comb begin
    sender_d = sender_q;
    stamp_d  = stamp_q;
    tok_d    = tok_i;
    if (match) begin
      tok_d.hit     = 1'b1;
      tok_d.limited = too_soon;
      if (!too_soon) begin
        stamp_d = tok_i.now;
      end
    end
    if (wr_i.en) begin
      sender_d = wr_i.sender;
      stamp_d  = wr_i.stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sender_q <= '0;
      stamp_q  <= '0;
      tok_q    <= '0;
    end else begin
      sender_q <= sender_d;
      stamp_q  <= stamp_d;
      tok_q    <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== sv/per_sender_cooldown_limiter.sv =====
// per_sender_cooldown_limiter: top level, request launch, cooldown registers,
// victim pointer and the row of psc_cell slots; depends on psc_pkg and psc_cell

// A request is taken when start is high and busy is low. It then walks the
// row of slot cells, one cell per clock. The answer appears on done_o /
// limited_o for one cycle when the request leaves the last cell, and busy
// drops at the edge that ends that cycle; no new request is taken while
// busy is high, so the row holds one request at a time. The result is
// shown once and cannot be held off: the receiver must take it in
// that cycle. Write the cooldown registers only while no request is in
// flight: busy low and start not raised at the same edge.

module per_sender_cooldown_limiter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [psc_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      start,
  input  logic [psc_pkg::IdW-1:0]   sender_id_i,
  input  logic [psc_pkg::TimeW-1:0] now_ms_i,
  input  logic                      is_direct_i,
  output logic                      busy,
  output logic                      done_o,
  output logic                      limited_o
);

  logic [psc_pkg::CfgW-1:0]    direct_cd_q, channel_cd_q;
  logic                        busy_q, busy_d;
  logic                        accept;
  logic [psc_pkg::VictimW-1:0] victim_q, victim_d;
  psc_pkg::token_t             req_q, req_d;
  psc_pkg::token_t             tok [psc_pkg::SlotCount+1];
  psc_pkg::token_t             tail;
  psc_pkg::slot_wr_t           wr [psc_pkg::SlotCount];
  logic                        miss;
  logic [psc_pkg::SlotCount:0] valid_vec;

  assign accept = start && !busy_q;
  assign tail   = tok[psc_pkg::SlotCount];
  assign miss   = tail.valid && !tail.hit;

  // cooldown registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_cd_q  <= psc_pkg::DirectCooldownRst;
      channel_cd_q <= psc_pkg::ChannelCooldownRst;
    end else if (cfg_we_i) begin
      unique case (psc_pkg::cfg_idx_e'(cfg_idx_i))
        psc_pkg::CFG_DIRECT_COOLDOWN:  direct_cd_q  <= cfg_wdata_i;
        psc_pkg::CFG_CHANNEL_COOLDOWN: channel_cd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request launch token
  always_comb begin
    req_d          = '0;
    req_d.valid    = accept;
    req_d.sender   = sender_id_i;
    req_d.now      = now_ms_i;
    req_d.cooldown = is_direct_i ? direct_cd_q : channel_cd_q;
  end

  // busy from accept until the result cycle
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tail.valid) begin
      busy_d = 1'b0;
    end
  end

  // round-robin victim pointer, advanced on a miss
  always_comb begin
    victim_d = victim_q;
    if (miss) begin
      if (victim_q == psc_pkg::VictimW'(psc_pkg::SlotCount - 1)) begin
        victim_d = '0;
      end else begin
        victim_d = victim_q + psc_pkg::VictimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      victim_q <= '0;
      req_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      victim_q <= victim_d;
      req_q    <= req_d;
    end
  end

  assign tok[0] = req_q;

  // row of slot cells
  for (genvar g = 0; g < psc_pkg::SlotCount; g++) begin : g_cell
    assign wr[g].en     = miss && (victim_q == psc_pkg::VictimW'(g));
    assign wr[g].sender = tail.sender;
    assign wr[g].stamp  = tail.now;

    psc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .wr_i   (wr[g]),
      .tok_o  (tok[g+1])
    );
  end

  // valid bits along the row, for checking
  for (genvar g = 0; g <= psc_pkg::SlotCount; g++) begin : g_vld
    assign valid_vec[g] = tok[g].valid;
  end

  assign busy      = busy_q;
  assign done_o    = tail.valid;
  assign limited_o = tail.valid && tail.limited;

`ifndef SYNTHESIS
  // at most one request in flight along the row
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(valid_vec))
    else $error("more than one request in the cell row");

  // a result only while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result without a request in flight");

  // busy drops right after the result
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after the result");

  // an accepted request launches into the row
  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && req_q.valid))
    else $error("accepted request not launched");

  // a sender with no matching slot always passes
  a_miss_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss |-> !limited_o)
    else $error("new sender limited");
`endif

endmodule
